[rtl/gsb_pkg.sv]
package gsb_pkg;

    localparam int unsigned VALUE_W   = 32;
    localparam int unsigned DEPTH_DEF = 64;

    // control shared by all cells of the chain
    typedef struct packed {
        logic insert;
        logic shift;
    } t_cell_ctl;

    // what a cell hands to its right-hand neighbor
    typedef struct packed {
        logic                      take;
        logic signed [VALUE_W-1:0] value;
    } t_link;

endpackage

[rtl/gnome_sort_buffer.sv]
// gnome_sort_buffer: stable ascending sorter for lists of signed 32-bit values
//
// input channel (i_valid / o_stall, i_value, i_last): one list element per
// beat, i_last on the final element. each accepted beat is placed at once
// into a row of DEPTH cells that always holds the list in sorted order;
// elements beyond DEPTH are dropped and the whole list is then reported
// with o_truncated set.
// output channel (o_valid / i_stall, o_sorted_value, o_last_out,
// o_truncated): after the final input beat the row drains from cell 0, one
// beat per cycle while i_stall is low, smallest value first; equal values
// keep arrival order. o_last_out marks the final beat of the list.
// the first result is offered in the cycle after the final input beat is
// accepted. o_stall is high for the whole drain, the row holds one list.
// when the receiver stalls, the row and the offered beat simply hold.
// reset (synchronous, active low) empties the row and returns to loading;
// the cell values themselves are not cleared, occupancy follows the count.
module gnome_sort_buffer
    import gsb_pkg::*;
#(
    parameter int unsigned DEPTH = DEPTH_DEF
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_valid,
    output logic                      o_stall,
    input  logic signed [VALUE_W-1:0] i_value,
    input  logic                      i_last,
    output logic                      o_valid,
    input  logic                      i_stall,
    output logic signed [VALUE_W-1:0] o_sorted_value,
    output logic                      o_last_out,
    output logic                      o_truncated
);

    localparam int unsigned CW = $clog2(DEPTH + 1);

    typedef enum logic [1:0] {
        S_LOAD  = 2'b01,
        S_DRAIN = 2'b10
    } t_state;

    t_state          r_state, n_state;
    logic [CW-1:0]   r_count, n_count;
    logic            r_ovf, n_ovf;

    logic            w_in_acc;
    logic            w_out_acc;
    logic            w_room;
    t_cell_ctl       w_ctl;
    logic [DEPTH-1:0] w_occ;
    t_link           w_link [DEPTH];

    // handshakes
    assign w_in_acc  = i_valid && (r_state == S_LOAD);
    assign w_out_acc = o_valid && !i_stall;
    assign w_room    = r_count < CW'(DEPTH);

    assign w_ctl.insert = w_in_acc && w_room;
    assign w_ctl.shift  = w_out_acc;

    // cell i holds a list element while i is below the count
    for (genvar g = 0; g < DEPTH; g++) begin : g_cells
        t_link                     w_left;
        logic signed [VALUE_W-1:0] w_right_value;

        assign w_occ[g] = r_count > CW'(g);

        if (g == 0) begin : g_first
            assign w_left = '{take: 1'b0, value: '0};
        end else begin : g_mid
            assign w_left = w_link[g-1];
        end

        if (g == DEPTH - 1) begin : g_end
            assign w_right_value = w_link[g].value;
        end else begin : g_inner
            assign w_right_value = w_link[g+1].value;
        end

        gsb_cell u_cell (
            .i_clk         (i_clk),
            .i_ctl         (w_ctl),
            .i_x           (i_value),
            .i_occ         (w_occ[g]),
            .i_left        (w_left),
            .i_right_value (w_right_value),
            .o_link        (w_link[g])
        );
    end

    // sequencing of load and drain
    always_comb begin
        n_state = r_state;
        n_count = r_count;
        n_ovf   = r_ovf;
        unique case (r_state)
            S_LOAD: begin
                if (w_in_acc) begin
                    if (w_room) begin
                        n_count = r_count + CW'(1);
                    end else begin
                        n_ovf = 1'b1;
                    end
                    if (i_last) begin
                        n_state = S_DRAIN;
                    end
                end
            end
            S_DRAIN: begin
                if (w_out_acc) begin
                    n_count = r_count - CW'(1);
                    if (r_count == CW'(1)) begin
                        n_state = S_LOAD;
                        n_ovf   = 1'b0;
                    end
                end
            end
            default: begin
                n_state = S_LOAD;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_LOAD;
            r_count <= '0;
            r_ovf   <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_ovf   <= n_ovf;
        end
    end

    // the head cell is the output register
    assign o_stall        = (r_state != S_LOAD);
    assign o_valid        = (r_state == S_DRAIN);
    assign o_sorted_value = w_link[0].value;
    assign o_last_out     = (r_count == CW'(1));
    assign o_truncated    = r_ovf;

    // a drain always has an element at the head
    a_drain_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DRAIN) |-> w_occ[0])
        else $error("drain with empty row");

    // the row stays in ascending order at the head
    a_head_sorted: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_occ[1] |-> !(w_link[0].value > w_link[1].value))
        else $error("head of row out of order");

    // the final beat leaves the row empty and loading again
    a_last_empties: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_out_acc && o_last_out) |=> (r_state == S_LOAD) && (r_count == '0) && !r_ovf)
        else $error("row not empty after final beat");

    // an element dropped on a full row sets the overflow flag
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_acc && !w_room |=> r_ovf)
        else $error("dropped element not flagged");

endmodule

[rtl/gsb_cell.sv]
module gsb_cell
    import gsb_pkg::*;
(
    input  logic                      i_clk,
    input  t_cell_ctl                 i_ctl,
    input  logic signed [VALUE_W-1:0] i_x,
    input  logic                      i_occ,
    input  t_link                     i_left,
    input  logic signed [VALUE_W-1:0] i_right_value,
    output t_link                     o_link
);

    logic signed [VALUE_W-1:0] r_value;
    logic signed [VALUE_W-1:0] n_value;
    logic                      w_take;

    // empty cells act as +infinity; equal values stay ahead of the new one
    assign w_take = !i_occ || (r_value > i_x);

    always_comb begin
        n_value = r_value;
        if (i_ctl.insert) begin
            if (i_left.take) begin
                n_value = i_left.value;
            end else if (w_take) begin
                n_value = i_x;
            end
        end else if (i_ctl.shift) begin
            n_value = i_right_value;
        end
    end

    always_ff @(posedge i_clk) begin
        r_value <= n_value;
    end

    assign o_link.take  = w_take;
    assign o_link.value = r_value;

endmodule
